FILE: design/serial_adc_interface_sequencer_top_macros.svh
// Assertion macros for the serial ADC sequencer checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef SERIAL_ADC_INTERFACE_SEQUENCER_TOP_MACROS_SVH
`define SERIAL_ADC_INTERFACE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SAIS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sais check failed");

// Next-cycle implication, checked out of reset.
`define SAIS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sais check failed");

`endif

FILE: design/sais_pkg.sv
// Shared types and constants for the serial ADC interface sequencer.
// No dependencies.
package sais_pkg;

    localparam int CODE_BITS   = 5;
    localparam int RESULT_BITS = 11;
    localparam int VALUE_W     = 11;
    localparam int CNT_W       = 5;
    localparam int ACQ_W       = 4;
    localparam int CONV_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_SELECT  = 2'd1;
    localparam logic [1:0] MODE_CONVERT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACQUIRE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SHIFT  = 3'd1,
        PH_ACQ    = 3'd2,
        PH_CONV   = 3'd3,
        PH_HALF   = 3'd4,
        PH_READ   = 3'd5,
        PH_FINISH = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase                 phase;
        logic [CNT_W-1:0]       bit_count;
        logic                   half_low;
        logic [CODE_BITS-1:0]   code_shift;
        logic                   is_conversion;
        logic [RESULT_BITS-1:0] data_shift;
        logic                   clock_level;
        logic                   select_level;
        logic                   data_level;
    } t_state;

    typedef struct packed {
        logic               sclk;
        logic               cs_n;
        logic               din;
        logic               busy_res;
        logic               start_rejected;
        logic               value_valid;
        logic [VALUE_W-1:0] value;
    } t_result;

endpackage

FILE: design/sais_step.sv
// Next-state and result logic for one request of the ADC sequencer.
// Depends on sais_pkg.
module sais_step (
    input  sais_pkg::t_state                    i_state,
    input  logic [sais_pkg::ACQ_W-1:0]          i_acquire_clocks,
    input  logic [sais_pkg::CONV_W-1:0]         i_convert_clocks,
    input  logic [1:0]                          i_mode,
    input  logic [sais_pkg::CODE_BITS-1:0]      i_code,
    input  logic                                i_dout_level,
    output sais_pkg::t_state                    o_state,
    output sais_pkg::t_result                   o_result
);

    sais_pkg::t_state            s;
    logic [sais_pkg::CNT_W-1:0]  bc_inc;
    logic [sais_pkg::CNT_W-1:0]  limit;
    logic                        rejected;
    logic                        valid;
    logic [sais_pkg::VALUE_W-1:0] word;

    assign bc_inc = i_state.bit_count + sais_pkg::CNT_W'(1);
    assign limit  = (i_state.phase == sais_pkg::PH_ACQ)
                  ? sais_pkg::CNT_W'(i_acquire_clocks) : sais_pkg::CNT_W'(i_convert_clocks);

    always_comb begin
        s        = i_state;
        rejected = 1'b0;
        valid    = 1'b0;
        word     = '0;
        if (i_mode == sais_pkg::MODE_SELECT || i_mode == sais_pkg::MODE_CONVERT) begin
            if (i_state.phase != sais_pkg::PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                s.clock_level   = 1'b1;
                s.select_level  = 1'b0;
                s.code_shift    = i_code;
                s.bit_count     = '0;
                s.half_low      = 1'b0;
                s.data_shift    = '0;
                s.is_conversion = (i_mode == sais_pkg::MODE_CONVERT);
                s.phase         = sais_pkg::PH_SHIFT;
            end
        end else if (i_mode == sais_pkg::MODE_TICK) begin
            unique case (i_state.phase)
                sais_pkg::PH_IDLE: begin
                end
                sais_pkg::PH_SHIFT: begin
                    if (!i_state.half_low) begin
                        s.clock_level = 1'b0;
                        s.data_level  = i_state.code_shift[0];
                        s.half_low    = 1'b1;
                    end else begin
                        s.clock_level = 1'b1;
                        s.half_low    = 1'b0;
                        s.code_shift  = i_state.code_shift >> 1;
                        s.bit_count   = bc_inc;
                        if (bc_inc >= sais_pkg::CNT_W'(sais_pkg::CODE_BITS)) begin
                            s.bit_count = '0;
                            if (i_state.is_conversion) begin
                                s.phase = sais_pkg::PH_ACQ;
                            end else begin
                                s.select_level = 1'b1;
                                s.phase        = sais_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                sais_pkg::PH_ACQ, sais_pkg::PH_CONV: begin
                    // idle clock periods; count on the rising half
                    if (!i_state.half_low) begin
                        s.clock_level = 1'b0;
                        s.half_low    = 1'b1;
                    end else begin
                        s.clock_level = 1'b1;
                        s.half_low    = 1'b0;
                        s.bit_count   = bc_inc;
                        if (bc_inc >= limit) begin
                            s.bit_count = '0;
                            s.phase = (i_state.phase == sais_pkg::PH_ACQ)
                                    ? sais_pkg::PH_CONV : sais_pkg::PH_HALF;
                        end
                    end
                end
                sais_pkg::PH_HALF: begin
                    s.clock_level = 1'b0;
                    s.bit_count   = '0;
                    s.half_low    = 1'b0;
                    s.phase       = sais_pkg::PH_READ;
                end
                sais_pkg::PH_READ: begin
                    if (!i_state.half_low) begin
                        s.clock_level = 1'b1;
                        for (int i = 0; i < sais_pkg::RESULT_BITS; i++) begin
                            s.data_shift[i] = i_state.data_shift[i]
                                | (i_dout_level && i_state.bit_count == sais_pkg::CNT_W'(i));
                        end
                        s.bit_count = bc_inc;
                        s.half_low  = 1'b1;
                    end else begin
                        s.clock_level = 1'b0;
                        s.half_low    = 1'b0;
                        if (i_state.bit_count >= sais_pkg::CNT_W'(sais_pkg::RESULT_BITS)) begin
                            s.bit_count = '0;
                            s.phase     = sais_pkg::PH_FINISH;
                        end
                    end
                end
                sais_pkg::PH_FINISH: begin
                    s.clock_level  = 1'b1;
                    s.select_level = 1'b1;
                    valid          = 1'b1;
                    word           = sais_pkg::VALUE_W'(i_state.data_shift);
                    s.phase        = sais_pkg::PH_IDLE;
                end
                default: begin
                    s.phase = sais_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign o_state                 = s;
    assign o_result.sclk           = s.clock_level;
    assign o_result.cs_n           = s.select_level;
    assign o_result.din            = s.data_level;
    assign o_result.busy_res       = (s.phase != sais_pkg::PH_IDLE);
    assign o_result.start_rejected = rejected;
    assign o_result.value_valid    = valid;
    assign o_result.value          = word;

endmodule

FILE: design/sais_state.sv
// Sequencer state and configuration registers around the step logic.
// Depends on sais_pkg and sais_step.
module sais_state (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [1:0]                          i_mode,
    input  logic [sais_pkg::CODE_BITS-1:0]      i_code,
    input  logic                                i_dout_level,
    input  logic                                i_cfg_we,
    input  logic [sais_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sais_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output sais_pkg::t_result                   o_result
);

    sais_pkg::t_state                r_state;
    sais_pkg::t_state                n_state;
    logic [sais_pkg::ACQ_W-1:0]      r_acquire_clocks;
    logic [sais_pkg::CONV_W-1:0]     r_convert_clocks;

    sais_step u_step (
        .i_state          (r_state),
        .i_acquire_clocks (r_acquire_clocks),
        .i_convert_clocks (r_convert_clocks),
        .i_mode           (i_mode),
        .i_code           (i_code),
        .i_dout_level     (i_dout_level),
        .o_state          (n_state),
        .o_result         (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= sais_pkg::PH_IDLE;
            r_state.bit_count     <= '0;
            r_state.half_low      <= 1'b0;
            r_state.code_shift    <= '0;
            r_state.is_conversion <= 1'b0;
            r_state.data_shift    <= '0;
            r_state.clock_level   <= 1'b1;
            r_state.select_level  <= 1'b1;
            r_state.data_level    <= 1'b1;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acquire_clocks <= sais_pkg::ACQ_W'(4);
            r_convert_clocks <= sais_pkg::CONV_W'(12);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sais_pkg::CFG_ACQUIRE: r_acquire_clocks <= i_cfg_data[sais_pkg::ACQ_W-1:0];
                sais_pkg::CFG_CONVERT: r_convert_clocks <= i_cfg_data[sais_pkg::CONV_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: design/serial_adc_interface_sequencer_top.sv
// Serial ADC sequencer: one request per unstalled cycle, input register -> step -> result register.
// An accepted request waits in the input register, then is stepped into the result register.
// Throughput: one request per cycle; an output stall holds the result and stops intake.
// Reset (synchronous, active low): idle, clock/select/data lines high, registers 4 and 12.
// Depends on sais_pkg and sais_state.
module serial_adc_interface_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sais_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sais_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_mode,
    input  logic [sais_pkg::CODE_BITS-1:0]      i_code,
    input  logic                                i_dout_level,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_sclk,
    output logic                                o_cs_n,
    output logic                                o_din,
    output logic                                o_busy_res,
    output logic                                o_start_rejected,
    output logic                                o_value_valid,
    output logic [sais_pkg::VALUE_W-1:0]        o_value
);

    logic                             r_in_valid;
    logic [1:0]                       r_mode;
    logic [sais_pkg::CODE_BITS-1:0]   r_code;
    logic                             r_dout_level;
    logic                             r_out_valid;
    sais_pkg::t_result                r_result;
    sais_pkg::t_result                n_result;
    logic                             fire;

    // step runs when a request is held and the result slot is free or draining
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode       <= i_mode;
            r_code       <= i_code;
            r_dout_level <= i_dout_level;
        end
    end

    sais_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_mode       (r_mode),
        .i_code       (r_code),
        .i_dout_level (r_dout_level),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sclk           = r_result.sclk;
    assign o_cs_n           = r_result.cs_n;
    assign o_din            = r_result.din;
    assign o_busy_res       = r_result.busy_res;
    assign o_start_rejected = r_result.start_rejected;
    assign o_value_valid    = r_result.value_valid;
    assign o_value          = r_result.value;

endmodule

FILE: design/sais_checker.sv
// Port-level checks for the serial ADC sequencer, bound to the top level.
// Depends on sais_pkg and serial_adc_interface_sequencer_top_macros.svh.
`include "serial_adc_interface_sequencer_top_macros.svh"

module sais_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic                                o_sclk,
    input  logic                                o_cs_n,
    input  logic                                o_busy_res,
    input  logic                                o_start_rejected,
    input  logic                                o_value_valid,
    input  logic [sais_pkg::VALUE_W-1:0]        o_value
);

    // a finished conversion leaves the part deselected with the clock high
    `SAIS_ASSERT_IMP(a_done_lines, o_valid && o_value_valid, !o_busy_res && o_cs_n && o_sclk)
    // idle means chip select is released
    `SAIS_ASSERT_IMP(a_idle_deselect, o_valid && !o_busy_res, o_cs_n)
    // a rejected start never disturbs a running sequence
    `SAIS_ASSERT_IMP(a_reject_busy, o_valid && o_start_rejected, o_busy_res && !o_value_valid)
    // word is clean outside completion
    `SAIS_ASSERT_IMP(a_value_zero, o_valid && !o_value_valid, o_value == '0)
    // stalled result holds
    `SAIS_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_value) && $stable(o_cs_n))

endmodule

bind serial_adc_interface_sequencer_top sais_checker u_sais_checker (.*);

FILE: verif/tb_serial_adc_interface_sequencer_top.sv
// Testbench for serial_adc_interface_sequencer_top: random and directed pin sequences,
// checked against an in-bench model of the sequencer.
// Depends on sais_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_serial_adc_interface_sequencer_top;

    // indexes with no register behind them; writes must be ignored
    localparam logic [sais_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [sais_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [1:0] MODE_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]                     mode;
        logic [sais_pkg::CODE_BITS-1:0] code;
        logic                           dout;
    } t_req;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [sais_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sais_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [1:0]                      i_mode = sais_pkg::MODE_TICK;
    logic [sais_pkg::CODE_BITS-1:0]  i_code = '0;
    logic                            i_dout_level = 1'b0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic                            o_sclk;
    logic                            o_cs_n;
    logic                            o_din;
    logic                            o_busy_res;
    logic                            o_start_rejected;
    logic                            o_value_valid;
    logic [sais_pkg::VALUE_W-1:0]    o_value;

    t_req                          pending_req[$];
    sais_pkg::t_result             expected_pins[$];
    sais_pkg::t_state              seq_st;
    logic [sais_pkg::ACQ_W-1:0]    acq_clocks;
    logic [sais_pkg::CONV_W-1:0]   conv_clocks;
    logic        req_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned errors = 0;
    int unsigned n_requests = 0;
    int unsigned n_words = 0;
    int unsigned n_rejected = 0;

    serial_adc_interface_sequencer_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_code           (i_code),
        .i_dout_level     (i_dout_level),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sclk           (o_sclk),
        .o_cs_n           (o_cs_n),
        .o_din            (o_din),
        .o_busy_res       (o_busy_res),
        .o_start_rejected (o_start_rejected),
        .o_value_valid    (o_value_valid),
        .o_value          (o_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // one half of a free-running clock period; true once the period count reaches limit
    function automatic bit idle_period(input logic [sais_pkg::CNT_W-1:0] limit);
        if (!seq_st.half_low) begin
            seq_st.clock_level = 1'b0;
            seq_st.half_low = 1'b1;
            return 1'b0;
        end
        seq_st.clock_level = 1'b1;
        seq_st.half_low = 1'b0;
        seq_st.bit_count = seq_st.bit_count + 1'b1;
        if (seq_st.bit_count >= limit) begin
            seq_st.bit_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sais_pkg::t_result adc_step(input logic [1:0] mode,
                                                   input logic [sais_pkg::CODE_BITS-1:0] code,
                                                   input logic dout);
        sais_pkg::t_result r;
        r = '0;
        if (mode == sais_pkg::MODE_SELECT || mode == sais_pkg::MODE_CONVERT) begin
            if (seq_st.phase != sais_pkg::PH_IDLE) begin
                r.start_rejected = 1'b1;
            end else begin
                seq_st.clock_level = 1'b1;
                seq_st.select_level = 1'b0;
                seq_st.code_shift = code;
                seq_st.bit_count = '0;
                seq_st.half_low = 1'b0;
                seq_st.data_shift = '0;
                seq_st.is_conversion = (mode == sais_pkg::MODE_CONVERT);
                seq_st.phase = sais_pkg::PH_SHIFT;
            end
        end else if (mode == sais_pkg::MODE_TICK) begin
            unique case (seq_st.phase)
                sais_pkg::PH_SHIFT: begin
                    if (!seq_st.half_low) begin
                        seq_st.clock_level = 1'b0;
                        seq_st.data_level = seq_st.code_shift[0];
                        seq_st.half_low = 1'b1;
                    end else begin
                        seq_st.clock_level = 1'b1;
                        seq_st.half_low = 1'b0;
                        seq_st.code_shift = seq_st.code_shift >> 1;
                        seq_st.bit_count = seq_st.bit_count + 1'b1;
                        if (seq_st.bit_count >= sais_pkg::CODE_BITS) begin
                            seq_st.bit_count = '0;
                            if (seq_st.is_conversion) begin
                                seq_st.phase = sais_pkg::PH_ACQ;
                            end else begin
                                seq_st.select_level = 1'b1;
                                seq_st.phase = sais_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                sais_pkg::PH_ACQ: begin
                    if (idle_period(sais_pkg::CNT_W'(acq_clocks)))
                        seq_st.phase = sais_pkg::PH_CONV;
                end
                sais_pkg::PH_CONV: begin
                    if (idle_period(sais_pkg::CNT_W'(conv_clocks)))
                        seq_st.phase = sais_pkg::PH_HALF;
                end
                sais_pkg::PH_HALF: begin
                    seq_st.clock_level = 1'b0;
                    seq_st.bit_count = '0;
                    seq_st.half_low = 1'b0;
                    seq_st.phase = sais_pkg::PH_READ;
                end
                sais_pkg::PH_READ: begin
                    // sample on the rising half, drop the clock on the next tick
                    if (!seq_st.half_low) begin
                        seq_st.clock_level = 1'b1;
                        if (dout && seq_st.bit_count < sais_pkg::RESULT_BITS)
                            seq_st.data_shift[seq_st.bit_count] = 1'b1;
                        seq_st.bit_count = seq_st.bit_count + 1'b1;
                        seq_st.half_low = 1'b1;
                    end else begin
                        seq_st.clock_level = 1'b0;
                        seq_st.half_low = 1'b0;
                        if (seq_st.bit_count >= sais_pkg::RESULT_BITS) begin
                            seq_st.bit_count = '0;
                            seq_st.phase = sais_pkg::PH_FINISH;
                        end
                    end
                end
                sais_pkg::PH_FINISH: begin
                    seq_st.clock_level = 1'b1;
                    seq_st.select_level = 1'b1;
                    r.value_valid = 1'b1;
                    r.value = seq_st.data_shift;
                    seq_st.phase = sais_pkg::PH_IDLE;
                end
                default: seq_st.phase = sais_pkg::PH_IDLE;
            endcase
        end
        r.sclk = seq_st.clock_level;
        r.cs_n = seq_st.select_level;
        r.din = seq_st.data_level;
        r.busy_res = (seq_st.phase != sais_pkg::PH_IDLE);
        return r;
    endfunction

    // driver: requests from the pending queue, payload held until accepted
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                r = pending_req.pop_front();
                i_valid <= 1'b1;
                i_mode <= r.mode;
                i_code <= r.code;
                i_dout_level <= r.dout;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: check results, then advance the model on accepted requests
    always @(posedge i_clk) begin
        sais_pkg::t_result want;
        sais_pkg::t_result got;
        if (i_rst_n) begin
            req_taken <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                got.sclk = o_sclk;
                got.cs_n = o_cs_n;
                got.din = o_din;
                got.busy_res = o_busy_res;
                got.start_rejected = o_start_rejected;
                got.value_valid = o_value_valid;
                got.value = o_value;
                if (expected_pins.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got);
                end else begin
                    want = expected_pins.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display({"%0t ns: result mismatch (sclk cs_n din busy rej vv value),",
                                  " expected %b %b %b %b %b %b %0d,",
                                  " actual %b %b %b %b %b %b %0d"},
                                 $time, want.sclk, want.cs_n, want.din, want.busy_res,
                                 want.start_rejected, want.value_valid, want.value,
                                 got.sclk, got.cs_n, got.din, got.busy_res,
                                 got.start_rejected, got.value_valid, got.value);
                    end
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sais_pkg::CFG_ACQUIRE: acq_clocks = i_cfg_data[sais_pkg::ACQ_W-1:0];
                    sais_pkg::CFG_CONVERT: conv_clocks = i_cfg_data[sais_pkg::CONV_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                want = adc_step(i_mode, i_code, i_dout_level);
                expected_pins.push_back(want);
                n_requests++;
                if (want.value_valid) n_words++;
                if (want.start_rejected) n_rejected++;
            end
        end
    end

    task automatic add_req(input logic [1:0] m, input logic [sais_pkg::CODE_BITS-1:0] c,
                           input logic d);
        t_req r;
        r.mode = m;
        r.code = c;
        r.dout = d;
        pending_req.push_back(r);
    endtask

    task automatic write_reg(input logic [sais_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sais_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_req.size() != 0 || i_valid || expected_pins.size() != 0)
            @(posedge i_clk);
    endtask

    // drain, then clock out any half-done sequence so registers change with the pins idle
    task automatic settle_idle();
        wait_drained();
        while (seq_st.phase != sais_pkg::PH_IDLE) begin
            repeat (8) add_req(sais_pkg::MODE_TICK, sais_pkg::CODE_BITS'($urandom),
                               1'($urandom));
            wait_drained();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // mostly complete select/conversion sequences, some cut short, with stray requests mixed in
    task automatic random_traffic(input int target);
        int n;
        int kind;
        int ticks;
        int acq_n;
        int conv_n;
        int strays;
        n = 0;
        while (n < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                acq_n = (acq_clocks == 0) ? 1 : acq_clocks;
                conv_n = (conv_clocks == 0) ? 1 : conv_clocks;
                ticks = 2 * sais_pkg::CODE_BITS;
                if (kind < 65) ticks += 2 * acq_n + 2 * conv_n + 2 + 2 * sais_pkg::RESULT_BITS;
                add_req((kind < 65) ? sais_pkg::MODE_CONVERT : sais_pkg::MODE_SELECT,
                        sais_pkg::CODE_BITS'($urandom), 1'($urandom));
                if ($urandom_range(0, 9) == 0) ticks = $urandom_range(1, ticks - 1);
                for (int k = 0; k < ticks; k++) begin
                    if ($urandom_range(0, 29) == 0) begin
                        add_req(2'($urandom_range(sais_pkg::MODE_SELECT, MODE_NOP)),
                                sais_pkg::CODE_BITS'($urandom), 1'($urandom));
                        n++;
                    end
                    add_req(sais_pkg::MODE_TICK, sais_pkg::CODE_BITS'($urandom), 1'($urandom));
                end
                n += ticks + 1;
            end else begin
                strays = $urandom_range(1, 4);
                repeat (strays)
                    add_req(2'($urandom_range(sais_pkg::MODE_TICK, MODE_NOP)),
                            sais_pkg::CODE_BITS'($urandom), 1'($urandom));
                n += strays;
            end
        end
    endtask

    initial begin
        seq_st = '0;
        seq_st.phase = sais_pkg::PH_IDLE;
        seq_st.clock_level = 1'b1;
        seq_st.select_level = 1'b1;
        seq_st.data_level = 1'b1;
        acq_clocks = 4'd4;
        conv_clocks = 5'd12;
        send_idle_pct = 15;
        recv_idle_pct = 80;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick, mode three, select-only writes, starts while busy
        add_req(sais_pkg::MODE_TICK, 5'h1F, 1'b1);
        add_req(MODE_NOP, 5'h1F, 1'b1);
        add_req(sais_pkg::MODE_SELECT, 5'h1F, 1'b0);
        repeat (3) add_req(sais_pkg::MODE_TICK, 5'h00, 1'b1);
        add_req(sais_pkg::MODE_CONVERT, 5'h00, 1'b1);
        add_req(sais_pkg::MODE_SELECT, 5'h15, 1'b0);
        add_req(MODE_NOP, 5'h0A, 1'b0);
        repeat (7) add_req(sais_pkg::MODE_TICK, 5'h1F, 1'b0);
        add_req(sais_pkg::MODE_SELECT, 5'h00, 1'b1);
        for (int k = 0; k < 10; k++) add_req(sais_pkg::MODE_TICK, 5'h00, k[0]);
        settle_idle();

        // zero registers behave as one period; spare indexes must not disturb anything
        write_reg(sais_pkg::CFG_ACQUIRE, 5'd0);
        write_reg(sais_pkg::CFG_CONVERT, 5'd0);
        write_reg(CFG_SPARE_2, 5'h1F);
        write_reg(CFG_SPARE_3, 5'h0A);
        random_traffic(250);
        settle_idle();

        send_idle_pct = 80;
        recv_idle_pct = 15;
        write_reg(sais_pkg::CFG_ACQUIRE, 5'd15);
        write_reg(sais_pkg::CFG_CONVERT, 5'd31);
        random_traffic(250);
        settle_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(sais_pkg::CFG_ACQUIRE, 5'd1);
        write_reg(sais_pkg::CFG_CONVERT, 5'd1);
        random_traffic(250);
        settle_idle();

        write_reg(sais_pkg::CFG_ACQUIRE, sais_pkg::CFG_DATA_W'($urandom_range(1, 15)));
        write_reg(sais_pkg::CFG_CONVERT, sais_pkg::CFG_DATA_W'($urandom_range(1, 31)));
        random_traffic(250);
        settle_idle();

        repeat (10) @(posedge i_clk);
        if (expected_pins.size() != 0) begin
            errors++;
            $display("%0t ns: expected %0d more results, actual none", $time, expected_pins.size());
        end
        $display("Sent %0d requests over five register settings and three stall patterns;",
                 n_requests);
        $display("%0d conversion words read back, %0d starts refused while busy, %0d errors.",
                 n_words, n_rejected, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timed out with %0d requests pending", pending_req.size() + expected_pins.size());
        $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/sais_pkg.sv
design/sais_step.sv
design/sais_state.sv
design/serial_adc_interface_sequencer_top.sv
design/sais_checker.sv
verif/tb_serial_adc_interface_sequencer_top.sv
